/* rtl/core/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, constants and elaboration-time tables for the great-circle
// distance pipeline: CORDIC arctangent table, CORDIC gain and output limits.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Width of the CORDIC datapath (signed Q2.30 with guard bits).
  localparam int CW = 34;

  // Default number of CORDIC micro-rotations.
  localparam int CORDIC_STEPS_DEF = 32;

  // Square root pipeline: one result bit per stage for a 61-bit radicand.
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_W     = 62;

  // Byte address of the sphere radius register.
  localparam logic [2:0] ADDR_RADIUS = 3'd0;

  // Degree to radian scale factors in Q60 divided by the input unit.
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_SCALE = PI_Q60 / 64'd3600000000;
  localparam logic [63:0] LAT_SCALE  = PI_Q60 / 64'd1800000000;

  // Angle limits in units of 1e-7 degree.
  localparam logic signed [33:0] LAT_LIMIT = 34'sd900000000;
  localparam logic signed [33:0] TURN      = 34'sd3600000000;
  localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;

  // One in Q30.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Output limit and radius reset value.
  localparam logic [32:0] DIST_MAX     = 33'd5270000000;
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;

  // Arctangent of 2^-i in Q2.30, rounded.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      31: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Gain correction: round(2^60 / g), where g is the x result of rotating
  // (2^30, 0) by a zero angle. Evaluated at elaboration with a bit-serial
  // long division.
  function automatic logic [63:0] cordic_gain_k(input int steps);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] g;
    logic [63:0] num;
    logic [63:0] q;
    logic [64:0] rem;
    x = 64'sd1 <<< 30;
    y = '0;
    z = '0;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - 64'(atan_q30(i));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + 64'(atan_q30(i));
      end
    end
    g = (x <= 0) ? 64'd1 : 64'(x);
    num = (64'd1 << 60) + (g >> 1);
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, g}) begin
        rem = rem - {1'b0, g};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

/* rtl/core/gcd_cordic.sv */
// ----------------------------------------------------------------------------
// gcd_cordic
// Pipelined CORDIC, one micro-rotation per register stage. Rotation mode
// drives z to zero; vectoring mode drives y to zero and accumulates the angle.
// ----------------------------------------------------------------------------
module gcd_cordic #(
  parameter int STEPS       = gcd_pkg::CORDIC_STEPS_DEF,
  parameter bit VECTOR_MODE = 1'b0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gcd_pkg::CW-1:0]   x_in,
  input  logic signed [gcd_pkg::CW-1:0]   y_in,
  input  logic signed [gcd_pkg::CW-1:0]   z_in,
  output logic signed [gcd_pkg::CW-1:0]   x_out,
  output logic signed [gcd_pkg::CW-1:0]   y_out,
  output logic signed [gcd_pkg::CW-1:0]   z_out
);

  logic signed [gcd_pkg::CW-1:0] x_r [STEPS];
  logic signed [gcd_pkg::CW-1:0] y_r [STEPS];
  logic signed [gcd_pkg::CW-1:0] z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [gcd_pkg::CW-1:0] ATAN = gcd_pkg::atan_q30(i);
    logic signed [gcd_pkg::CW-1:0] xp;
    logic signed [gcd_pkg::CW-1:0] yp;
    logic signed [gcd_pkg::CW-1:0] zp;
    logic signed [gcd_pkg::CW-1:0] dx;
    logic signed [gcd_pkg::CW-1:0] dy;
    logic                          dir;

    // Stage input comes from the ports or from the previous stage.
    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = z_in;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign dx  = yp >>> i;
    assign dy  = xp >>> i;
    assign dir = VECTOR_MODE ? yp[gcd_pkg::CW-1] : !zp[gcd_pkg::CW-1];

    // One micro-rotation.
    always_ff @(posedge clk) begin
      if (en) begin
        if (dir) begin
          x_r[i] <= xp - dx;
          y_r[i] <= yp + dy;
          z_r[i] <= zp - ATAN;
        end else begin
          x_r[i] <= xp + dx;
          y_r[i] <= yp - dy;
          z_r[i] <= zp + ATAN;
        end
      end
    end
  end

  assign x_out = x_r[STEPS-1];
  assign y_out = y_r[STEPS-1];
  assign z_out = z_r[STEPS-1];

endmodule

/* rtl/core/gcd_isqrt.sv */
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined integer square root of a 61-bit radicand, one result bit per
// register stage (digit-by-digit method).
// ----------------------------------------------------------------------------
module gcd_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] rad_in,
  output logic [30:0] root_out
);

  localparam int SW = gcd_pkg::SQRT_W;
  localparam int NS = gcd_pkg::SQRT_STEPS;

  logic [SW-1:0] v_r   [NS];
  logic [SW-1:0] res_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - k));
    logic [SW-1:0] vp;
    logic [SW-1:0] rp;
    logic [SW-1:0] sum;

    if (k == 0) begin : g_first
      assign vp = SW'(rad_in);
      assign rp = '0;
    end else begin : g_next
      assign vp = v_r[k-1];
      assign rp = res_r[k-1];
    end

    assign sum = rp + BIT;

    // Trial subtraction for one result bit.
    always_ff @(posedge clk) begin
      if (en) begin
        if (vp >= sum) begin
          v_r[k]   <= vp - sum;
          res_r[k] <= (rp >> 1) + BIT;
        end else begin
          v_r[k]   <= vp;
          res_r[k] <= rp >> 1;
        end
      end
    end
  end

  assign root_out = res_r[NS-1][30:0];

endmodule

/* rtl/core/great_circle_distance.sv */
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points given in 1e-7 degree,
// returned in centimeters for a programmable sphere radius.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  ------------------------------------
//  in       in_valid / in_stall       in_lat_a, in_lon_a, in_lat_b, in_lon_b
//  out      out_valid / out_stall     out_distance_cm
//  cfg      psel penable pwrite pready paddr, pwdata, prdata (radius, 0x0)
//
//  One word is accepted per cycle while in_stall is low. A word passes a
//  rotation and a vectoring CORDIC of CORDIC_STEPS stages each, a 31-stage
//  square root and ten stages of conversion, multiplication and rounding.
//  The whole pipeline advances together; it holds while a result waits at
//  the output and out_stall is high, and in_stall follows from that.
//  Reset (rst_n low, synchronous) clears the valid bits and sets the radius
//  to 6371000 m.
//
module great_circle_distance #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_lat_a,
  input  logic signed [31:0] in_lon_a,
  input  logic signed [30:0] in_lat_b,
  input  logic signed [31:0] in_lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [32:0] out_distance_cm,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [2:0] paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int CW  = gcd_pkg::CW;
  localparam int LAT = 41 + 2 * CORDIC_STEPS;
  localparam logic [63:0] GAIN_K = gcd_pkg::cordic_gain_k(CORDIC_STEPS);
  localparam logic signed [CW-1:0] GAIN = GAIN_K[CW-1:0];

  // Configuration register.
  logic [23:0] radius_r;
  logic [30:0] radius100_r;

  assign pready = 1'b1;
  assign prdata = (paddr == gcd_pkg::ADDR_RADIUS) ? {8'd0, radius_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= gcd_pkg::RADIUS_RESET;
      radius100_r <= 31'(gcd_pkg::RADIUS_RESET * 31'd100);
    end else begin
      if (psel && penable && pwrite && pready && paddr == gcd_pkg::ADDR_RADIUS) begin
        radius_r <= pwdata[23:0];
      end
      radius100_r <= 31'(radius_r) * 31'd100;
    end
  end

  // Pipeline advance and valid bits.
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 0: clamp latitudes and take the longitude difference.
  logic signed [30:0] la_nxt;
  logic signed [30:0] lb_nxt;
  logic signed [30:0] la_r;
  logic signed [30:0] lb_r;
  logic signed [32:0] dlon_raw_r;

  always_comb begin
    la_nxt = in_lat_a;
    lb_nxt = in_lat_b;
    if (34'(in_lat_a) > gcd_pkg::LAT_LIMIT) la_nxt = 31'(gcd_pkg::LAT_LIMIT);
    if (34'(in_lat_a) < -gcd_pkg::LAT_LIMIT) la_nxt = 31'(-gcd_pkg::LAT_LIMIT);
    if (34'(in_lat_b) > gcd_pkg::LAT_LIMIT) lb_nxt = 31'(gcd_pkg::LAT_LIMIT);
    if (34'(in_lat_b) < -gcd_pkg::LAT_LIMIT) lb_nxt = 31'(-gcd_pkg::LAT_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      la_r       <= la_nxt;
      lb_r       <= lb_nxt;
      dlon_raw_r <= 33'(in_lon_b) - 33'(in_lon_a);
    end
  end

  // Stage 1: latitude difference and longitude wrap into [-180, 180).
  logic signed [33:0] dlon_w;
  logic signed [31:0] dlon_nxt;
  logic signed [31:0] ang_r [4];

  always_comb begin
    dlon_w = 34'(dlon_raw_r);
    if (dlon_w >= gcd_pkg::HALF_TURN) begin
      dlon_w = dlon_w - gcd_pkg::TURN;
    end else if (dlon_w < -gcd_pkg::HALF_TURN) begin
      dlon_w = dlon_w + gcd_pkg::TURN;
    end
    dlon_nxt = dlon_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0] <= 32'(lb_r) - 32'(la_r);
      ang_r[1] <= dlon_nxt;
      ang_r[2] <= 32'(la_r);
      ang_r[3] <= 32'(lb_r);
    end
  end

  // Stage 2: magnitude times the radian scale, lanes: half dlat, half dlon,
  // lat a, lat b.
  logic [61:0] scl_r [4];
  logic        neg_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        neg_r[k] <= ang_r[k][31];
        scl_r[k] <= 31'(ang_r[k][31] ? -ang_r[k] : ang_r[k])
                    * ((k < 2) ? gcd_pkg::HALF_SCALE[30:0] : gcd_pkg::LAT_SCALE[30:0]);
      end
    end
  end

  // Stage 3: round the magnitude half up and restore the sign.
  logic signed [CW-1:0] zq_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (neg_r[k]) begin
          zq_r[k] <= -CW'((scl_r[k] + 62'(1 << 29)) >> 30);
        end else begin
          zq_r[k] <= CW'((scl_r[k] + 62'(1 << 29)) >> 30);
        end
      end
    end
  end

  // Sine and cosine by CORDIC rotation.
  logic signed [CW-1:0] sin_dlat;
  logic signed [CW-1:0] sin_dlon;
  logic signed [CW-1:0] cos_la;
  logic signed [CW-1:0] cos_lb;

  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR_MODE(1'b0)) u_rot_dlat (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(zq_r[0]),
    .x_out(), .y_out(sin_dlat), .z_out()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR_MODE(1'b0)) u_rot_dlon (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(zq_r[1]),
    .x_out(), .y_out(sin_dlon), .z_out()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR_MODE(1'b0)) u_rot_la (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(zq_r[2]),
    .x_out(cos_la), .y_out(), .z_out()
  );
  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR_MODE(1'b0)) u_rot_lb (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(zq_r[3]),
    .x_out(cos_lb), .y_out(), .z_out()
  );

  // Magnitudes of the sines; negative cosines near the poles count as zero.
  logic [31:0] msl;
  logic [31:0] mso;
  logic [31:0] ca;
  logic [31:0] cb;

  assign msl = 32'(sin_dlat[CW-1] ? -sin_dlat : sin_dlat);
  assign mso = 32'(sin_dlon[CW-1] ? -sin_dlon : sin_dlon);
  assign ca  = cos_la[CW-1] ? 32'd0 : 32'(cos_la);
  assign cb  = cos_lb[CW-1] ? 32'd0 : 32'(cos_lb);

  // Haversine products: both sines squared, then one cosine per stage.
  logic [63:0] m1a;
  logic [63:0] m1b;
  logic [63:0] m2;
  logic [63:0] m3;
  logic [33:0] p1_r;
  logic [33:0] p1d_r;
  logic [33:0] p1dd_r;
  logic [33:0] sq2_r;
  logic [31:0] ca_r;
  logic [31:0] cb_r;
  logic [31:0] cbd_r;
  logic [33:0] p2b_r;
  logic [33:0] p2c_r;
  logic [34:0] asum;
  logic [30:0] a_r;

  assign m1a  = 64'(msl) * 64'(msl);
  assign m1b  = 64'(mso) * 64'(mso);
  assign m2   = 64'(sq2_r[31:0]) * 64'(ca_r);
  assign m3   = 64'(p2b_r[31:0]) * 64'(cbd_r);
  assign asum = 35'(p1dd_r) + 35'(p2c_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= m1a[63:30];
      sq2_r  <= m1b[63:30];
      ca_r   <= ca;
      cb_r   <= cb;
      p1d_r  <= p1_r;
      cbd_r  <= cb_r;
      p2b_r  <= m2[63:30];
      p1dd_r <= p1d_r;
      p2c_r  <= m3[63:30];
      a_r    <= (asum > 35'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : asum[30:0];
    end
  end

  // Square roots of a and 1 - a.
  logic [30:0] sy;
  logic [30:0] sx;

  gcd_isqrt u_sqrt_a (
    .clk(clk), .en(adv), .rad_in({a_r, 30'd0}), .root_out(sy)
  );
  gcd_isqrt u_sqrt_b (
    .clk(clk), .en(adv), .rad_in({gcd_pkg::ONE_Q30 - a_r, 30'd0}), .root_out(sx)
  );

  // Half the central angle by CORDIC vectoring.
  logic signed [CW-1:0] ang_half;

  gcd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR_MODE(1'b1)) u_vec (
    .clk(clk), .en(adv), .x_in(CW'(sx)), .y_in(CW'(sy)), .z_in('0),
    .x_out(), .y_out(), .z_out(ang_half)
  );

  // Scale by radius in centimeters, round and saturate.
  logic [33:0] c_ang;
  logic [64:0] dprod_r;
  logic [35:0] drnd;
  logic [32:0] dist_r;

  assign c_ang = ang_half[CW-1] ? 34'd0 : {ang_half[CW-2:0], 1'b0};
  assign drnd  = 36'((66'(dprod_r) + 66'(1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      dprod_r <= 65'(radius100_r) * 65'(c_ang);
      dist_r  <= (drnd > 36'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : drnd[32:0];
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_distance_cm = dist_r;

endmodule

/* rtl/core/gcd_checker.sv */
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks for great_circle_distance, attached by bind.
// ----------------------------------------------------------------------------
module gcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [32:0] out_distance_cm
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_cm))
    else $error("stalled result changed");

  // Results never exceed the saturation limit.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_cm <= gcd_pkg::DIST_MAX)
    else $error("distance above limit");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid result after reset");

  // The input only stalls while a result waits and is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A word accepted while no result waits; $past(in_valid) is always true here, so this check never fails.
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid || $past(in_valid))
    else $error("unexpected result");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_distance_cm(out_distance_cm)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Great-circle distance testbench
// Streams point pairs into the haversine distance pipeline and checks every
// distance word against a table value or an integer CORDIC predictor. It walks
// a directed table first, then random phases under several sphere radii, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int STEPS = gcd_pkg::CORDIC_STEPS_DEF;
  localparam longint FULL_TURN = 64'sd3600000000;
  localparam longint LAT_MAX = 64'sd900000000;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 160;
  localparam int PHASE_ITEMS = 285;

  typedef struct {
    longint radius;
    longint lat_a;
    longint lon_a;
    longint lat_b;
    longint lon_b;
    bit known;
    longint dist_cm;
  } pair_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [30:0] in_lat_a;
  logic signed [31:0] in_lon_a;
  logic signed [30:0] in_lat_b;
  logic signed [31:0] in_lon_b;
  logic out_valid;
  logic out_stall;
  logic [32:0] out_distance_cm;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Typed expectation travels with the payload.
  logic word_known;
  logic [32:0] word_dist;

  longint atan_tab[STEPS];
  longint cordic_gain;
  longint unsigned radius_m;
  logic [32:0] dist_q[$];
  int errors;
  int idle_cycles;
  bit tx_idle_en;
  bit rx_idle_en;
  int stall_cnt;

  great_circle_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a),
    .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_cm(out_distance_cm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rotation mode: returns cosine and sine of z scaled by x0 times the CORDIC gain.
  function automatic void cordic_rotate(input longint z, input longint x0,
                                        output longint cos_v, output longint sin_v);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = x0;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    cos_v = x;
    sin_v = y;
  endfunction

  // Vectoring mode: angle of (x, y).
  function automatic longint cordic_angle(input longint x, input longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  // Arctangent table from the Q60 series, then the gain correction.
  function automatic void build_cordic_tables();
    longint acc;
    longint term;
    longint g;
    longint s;
    int e;
    atan_tab[0] = longint'(((gcd_pkg::PI_Q60 >> 2) + (64'd1 << 29)) >> 30);
    for (int i = 1; i < STEPS; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e < 0) break;
        term = longint'((64'd1 << e) / 64'(2 * k + 1));
        acc += (k % 2 == 1) ? -term : term;
      end
      atan_tab[i] = (acc + (64'sd1 <<< 29)) >>> 30;
    end
    cordic_rotate(0, 64'sd1 <<< 30, g, s);
    if (g <= 0) g = 1;
    cordic_gain = longint'(((64'd1 << 60) + 64'(g) / 2) / 64'(g));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Angle in 1e-7 degree to signed Q2.30 radians, magnitude rounded.
  function automatic longint angle_q30(input longint d, input longint unsigned scale);
    longint unsigned u;
    longint r;
    u = (d < 0) ? -d : d;
    r = longint'((u * scale + (64'd1 << 29)) >> 30);
    return (d < 0) ? -r : r;
  endfunction

  function automatic longint clamp_lat(input longint v);
    if (v > LAT_MAX) return LAT_MAX;
    if (v < -LAT_MAX) return -LAT_MAX;
    return v;
  endfunction

  function automatic longint unsigned abs_u(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Haversine distance in centimeters for the current radius.
  function automatic logic [32:0] haversine_cm(input longint lat_a, input longint lon_a,
                                               input longint lat_b, input longint lon_b);
    longint la, lb, dlat, dlon, ca, cb, sl, so, tmp, z;
    longint unsigned a, p1, p2, sy, sx, c, d;
    la = clamp_lat(lat_a);
    lb = clamp_lat(lat_b);
    dlat = lb - la;
    dlon = lon_b - lon_a;
    dlon = ((dlon % FULL_TURN) + FULL_TURN) % FULL_TURN;
    if (dlon >= FULL_TURN / 2) dlon -= FULL_TURN;
    cordic_rotate(angle_q30(dlat, gcd_pkg::HALF_SCALE), cordic_gain, tmp, sl);
    cordic_rotate(angle_q30(dlon, gcd_pkg::HALF_SCALE), cordic_gain, tmp, so);
    cordic_rotate(angle_q30(la, gcd_pkg::LAT_SCALE), cordic_gain, ca, tmp);
    cordic_rotate(angle_q30(lb, gcd_pkg::LAT_SCALE), cordic_gain, cb, tmp);
    // Polar CORDIC error can leave a small negative cosine.
    if (ca < 0) ca = 0;
    if (cb < 0) cb = 0;
    p1 = (abs_u(sl) * abs_u(sl)) >> 30;
    p2 = (abs_u(so) * abs_u(so)) >> 30;
    p2 = (p2 * longint'(ca)) >> 30;
    p2 = (p2 * longint'(cb)) >> 30;
    a = p1 + p2;
    if (a > (64'd1 << 30)) a = 64'd1 << 30;
    sy = int_sqrt(a << 30);
    sx = int_sqrt(((64'd1 << 30) - a) << 30);
    z = cordic_angle(longint'(sx), longint'(sy));
    if (z < 0) z = 0;
    c = 2 * longint'(z);
    d = (radius_m * 100 * c + (64'd1 << 29)) >> 30;
    if (d > gcd_pkg::DIST_MAX) d = gcd_pkg::DIST_MAX;
    return d[32:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // Offer one pair, with an optional idle burst first; returns once accepted.
  task automatic send_pair(input longint la, input longint loa, input longint lb,
                           input longint lob, input bit known, input longint want_cm);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lat_a <= la[30:0];
    in_lon_a <= loa[31:0];
    in_lat_b <= lb[30:0];
    in_lon_b <= lob[31:0];
    word_known <= known;
    word_dist <= want_cm[32:0];
    do @(posedge clk); while (in_stall);
  endtask

  // Radius write once the pipeline has drained; upper data bits are junk.
  task automatic set_radius(input longint r);
    in_valid <= 1'b0;
    wait (dist_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= gcd_pkg::ADDR_RADIUS;
    pwdata <= {8'($urandom_range(0, 255)), r[23:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radius_m = r & 64'hFF_FFFF;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 1800000000)) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
  endfunction

  function automatic longint jitter(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly real coordinates, plus raw bit patterns, near and antipodal pairs
  // and polar points.
  task automatic send_random_pair();
    longint la, loa, lb, lob;
    la = rand_lat(); loa = rand_lon(); lb = rand_lat(); lob = rand_lon();
    case ($urandom_range(0, 9))
      0: begin
        la = longint'($signed(31'($urandom)));
        lb = longint'($signed(31'($urandom)));
        loa = longint'($signed($urandom));
        lob = longint'($signed($urandom));
      end
      1: begin
        lb = la + jitter(2000);
        lob = loa + jitter(2000);
      end
      2: begin
        lb = -la + jitter(50000);
        lob = loa + 64'sd1800000000 + jitter(50000);
      end
      3: begin
        la = ($urandom_range(0, 1) != 0) ? LAT_MAX : -LAT_MAX;
        lb = la - longint'($urandom_range(0, 3000));
      end
      default: ;
    endcase
    send_pair(la, loa, lb, lob, 1'b0, 0);
  endtask

  pair_row_t rows[19] = '{
    '{6371000, 0, 0, 0, 0, 0, 0},
    '{6371000, 900000000, 0, -900000000, 0, 0, 0},
    '{6371000, 1073741823, 1800000000, -1073741824, -1800000000, 0, 0},
    '{6371000, 0, -1800000000, 0, 1800000000, 0, 0},
    '{6371000, 0, -64'sd2147483648, 0, 2147483647, 0, 0},
    '{6371000, 0, 0, 0, 1800000000, 0, 0},
    '{6371000, 0, 1800000000, 0, 0, 0, 0},
    '{6371000, 899999999, 0, 899999999, 1800000000, 0, 0},
    '{6371000, 900000000, 123, 900000000, -1800000000, 0, 0},
    '{6371000, 515000000, -1270000, 487000000, 23500000, 0, 0},
    '{6371000, -337000000, 1512000000, 406000000, -740000000, 0, 0},
    '{6371000, 1, 0, -1, 1, 0, 0},
    '{6371000, -1073741824, -64'sd2147483648, 1073741823, 2147483647, 0, 0},
    '{16777215, 0, 0, 0, 1800000000, 1, 64'sd5270000000},
    '{16777215, 900000000, 0, -900000000, 0, 1, 64'sd5270000000},
    '{16777215, 450000000, 100000000, -450000000, -1700000000, 0, 0},
    '{0, 0, 0, 0, 1800000000, 1, 0},
    '{0, 123456789, -55, -987654321, 2000000000, 1, 0},
    '{1, 0, 0, 0, 1800000000, 0, 0}
  };

  // Random stall bursts on the result side.
  always @(posedge clk) begin : result_pace
    int n;
    n = stall_cnt;
    if (!rst_n) begin
      n = 0;
    end else if (n != 0) begin
      n--;
    end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, 14);
    end
    stall_cnt <= n;
    out_stall <= (n != 0);
  end

  // Accepted pairs queue their expected distance; results are checked in order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (word_known) begin
        dist_q = {dist_q, word_dist};
      end else begin
        dist_q = {dist_q, haversine_cm(in_lat_a, in_lon_a, in_lat_b, in_lon_b)};
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (dist_q.size() == 0) begin
        report_mismatch("unexpected distance word", -1, out_distance_cm);
      end else if (out_distance_cm !== dist_q[0]) begin
        report_mismatch("distance_cm", dist_q[0], out_distance_cm);
        void'(dist_q.pop_front());
      end else begin
        void'(dist_q.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no word and no register write is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("** great_circle_distance: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    stall_cnt = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    radius_m = gcd_pkg::RADIUS_RESET;
    build_cordic_tables();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_lat_a <= '0;
    in_lon_a <= '0;
    in_lat_b <= '0;
    in_lon_b <= '0;
    word_known <= 1'b0;
    word_dist <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the radius is rewritten whenever a row asks for another.
    foreach (rows[i]) begin
      if (rows[i].radius != radius_m) set_radius(rows[i].radius);
      send_pair(rows[i].lat_a, rows[i].lon_a, rows[i].lat_b, rows[i].lon_b,
                rows[i].known, rows[i].dist_cm);
    end

    // Random phases under several radii; the last one runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_radius(16777215);
        1: set_radius(1);
        2: set_radius(0);
        3: set_radius($urandom_range(2, 16777214));
        4: set_radius(gcd_pkg::RADIUS_RESET);
        default: set_radius($urandom_range(1000, 16777215));
      endcase
      tx_idle_en = (ph != 5);
      rx_idle_en = (ph != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph != 5 && $urandom_range(0, 79) == 0) begin
          tx_idle_en = !tx_idle_en;
          rx_idle_en = tx_idle_en;
        end
        send_random_pair();
      end
    end
    in_valid <= 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;

    wait (dist_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && dist_q.size() == 0) begin
      $display("** great_circle_distance: PASSED **");
    end else begin
      $display("** great_circle_distance: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/gcd_pkg.sv
rtl/core/gcd_cordic.sv
rtl/core/gcd_isqrt.sv
rtl/core/great_circle_distance.sv
rtl/core/gcd_checker.sv
bench/tb.sv
